// ===== sv/ttt_pkg.sv =====
package ttt_pkg;

  // Integer accumulator width; the magnitude is clamped at 2^(INT_WIDTH-1).
  localparam int INT_WIDTH = 32;
  localparam int PROD_W    = INT_WIDTH + 4;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Result kinds.
  localparam logic [3:0] K_TEXT   = 4'd0;
  localparam logic [3:0] K_LBRACE = 4'd1;
  localparam logic [3:0] K_RBRACE = 4'd2;
  localparam logic [3:0] K_LBRACK = 4'd3;
  localparam logic [3:0] K_RBRACK = 4'd4;
  localparam logic [3:0] K_EQUAL  = 4'd5;
  localparam logic [3:0] K_COMMA  = 4'd6;
  localparam logic [3:0] K_STRING = 4'd7;
  localparam logic [3:0] K_IDENT  = 4'd8;
  localparam logic [3:0] K_EXPR   = 4'd9;
  localparam logic [3:0] K_BOOL   = 4'd10;
  localparam logic [3:0] K_INT    = 4'd11;
  localparam logic [3:0] K_EOF    = 4'd12;

  // Keyword match progress: 1..4 along "true", 5..9 along "false".
  localparam logic [3:0] KM_NONE  = 4'd0;
  localparam logic [3:0] KM_T     = 4'd1;
  localparam logic [3:0] KM_TR    = 4'd2;
  localparam logic [3:0] KM_TRU   = 4'd3;
  localparam logic [3:0] KM_TRUE  = 4'd4;
  localparam logic [3:0] KM_F     = 4'd5;
  localparam logic [3:0] KM_FA    = 4'd6;
  localparam logic [3:0] KM_FAL   = 4'd7;
  localparam logic [3:0] KM_FALS  = 4'd8;
  localparam logic [3:0] KM_FALSE = 4'd9;

  // Number flag bits.
  localparam int F_NEG   = 0;
  localparam int F_STOP  = 1;
  localparam int F_FLOAT = 2;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  text;
    logic [31:0] value;
  } tok_res_t;

  typedef struct packed {
    logic     two;
    tok_res_t r0;
    tok_res_t r1;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  typedef struct packed {
    logic [INT_WIDTH-1:0] acc;
    logic [2:0]           flags;
  } num_t;

  function automatic tok_res_t mk_res(logic [3:0] kind, logic [7:0] text, logic [31:0] value);
    tok_res_t r;
    r.kind  = kind;
    r.text  = text;
    r.value = value;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [3:0] keyword_next(logic [3:0] km, logic [7:0] c);
    logic [3:0] r;
    r = KM_NONE;
    unique case (km)
      KM_T:    if (c == "r") r = KM_TR;
      KM_TR:   if (c == "u") r = KM_TRU;
      KM_TRU:  if (c == "e") r = KM_TRUE;
      KM_F:    if (c == "a") r = KM_FA;
      KM_FA:   if (c == "l") r = KM_FAL;
      KM_FAL:  if (c == "s") r = KM_FALS;
      KM_FALS: if (c == "e") r = KM_FALSE;
      default: r = KM_NONE;
    endcase
    return r;
  endfunction

  // One character inside a number: accumulate digits with saturation, stop on '-', '.', 'e'.
  function automatic num_t num_step(num_t n, logic [7:0] c);
    num_t                 r;
    logic [PROD_W-1:0]    t;
    logic [PROD_W-1:0]    lim;
    r   = n;
    lim = PROD_W'(1) << (INT_WIDTH - 1);
    t   = (PROD_W'(n.acc) << 3) + (PROD_W'(n.acc) << 1) + PROD_W'(c - "0");
    if (is_digit(c)) begin
      if (!n.flags[F_STOP]) begin
        if (t > lim) r.acc = lim[INT_WIDTH-1:0];
        else r.acc = t[INT_WIDTH-1:0];
      end
    end else if (c == "-") begin
      r.flags[F_STOP] = 1'b1;
    end else begin
      r.flags[F_STOP]  = 1'b1;
      r.flags[F_FLOAT] = 1'b1;
    end
    return r;
  endfunction

  function automatic tok_res_t finish_number(num_t n);
    logic signed [INT_WIDTH-1:0] v;
    logic [INT_WIDTH-1:0]        lim;
    lim = INT_WIDTH'(1) << (INT_WIDTH - 1);
    if (n.flags[F_NEG]) v = -n.acc;
    else if (n.acc >= lim) v = lim - INT_WIDTH'(1);
    else v = n.acc;
    if (n.flags[F_FLOAT]) return mk_res(K_EXPR, 8'd0, 32'd0);
    return mk_res(K_INT, 8'd0, 32'(v));
  endfunction

  function automatic tok_res_t finish_word(logic [3:0] km);
    if (km == KM_TRUE) return mk_res(K_BOOL, 8'd0, 32'd1);
    if (km == KM_FALSE) return mk_res(K_BOOL, 8'd0, 32'd0);
    return mk_res(K_IDENT, 8'd0, 32'd0);
  endfunction

endpackage

// ===== sv/ttt_front.sv =====
module ttt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_input_byte,
  input  logic              in_end_of_input,
  input  ttt_pkg::q_stat_t  q_stat,
  output logic              push,
  output ttt_pkg::q_entry_t push_entry
);
  import ttt_pkg::*;

  typedef enum logic [3:0] {
    M_START, M_SLASH, M_LINE, M_BLOCK, M_STAR, M_STRING,
    M_ESC, M_IDENT, M_CALL, M_CALLQ, M_NUMBER, M_HALT
  } scan_mode_t;

  scan_mode_t mode_r, mode_nxt;
  logic [3:0] km_r, km_nxt;
  num_t       num_r, num_nxt;

  logic [7:0] c;
  logic       is_end;
  logic       accept;

  // Outcome of scanning c as the first byte of a token.
  scan_mode_t st_mode;
  logic       st_emit;
  tok_res_t   st_res;
  logic       st_ident;
  logic       st_num;
  logic [3:0] st_km;
  num_t       st_numv;

  tok_res_t   res0, res1;
  logic [1:0] n_res;

  assign c        = in_input_byte;
  assign is_end   = in_end_of_input || (c == 8'd0);
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    st_mode  = M_START;
    st_emit  = 1'b0;
    st_res   = mk_res(K_TEXT, c, 32'd0);
    st_ident = 1'b0;
    st_num   = 1'b0;
    st_km    = KM_NONE;
    st_numv  = num_step('0, c);
    if (c == "-") begin
      st_numv.acc   = '0;
      st_numv.flags = '0;
      st_numv.flags[F_NEG] = 1'b1;
    end
    priority if (is_space(c)) begin
      st_mode = M_START;
    end else if (c == "/") begin
      st_mode = M_SLASH;
    end else if (c == "{") begin
      st_emit = 1'b1;
      st_res  = mk_res(K_LBRACE, 8'd0, 32'd0);
    end else if (c == "}") begin
      st_emit = 1'b1;
      st_res  = mk_res(K_RBRACE, 8'd0, 32'd0);
    end else if (c == "[") begin
      st_emit = 1'b1;
      st_res  = mk_res(K_LBRACK, 8'd0, 32'd0);
    end else if (c == "]") begin
      st_emit = 1'b1;
      st_res  = mk_res(K_RBRACK, 8'd0, 32'd0);
    end else if (c == "=") begin
      st_emit = 1'b1;
      st_res  = mk_res(K_EQUAL, 8'd0, 32'd0);
    end else if (c == ",") begin
      st_emit = 1'b1;
      st_res  = mk_res(K_COMMA, 8'd0, 32'd0);
    end else if (c == "\"") begin
      st_mode = M_STRING;
    end else if (is_alpha(c)) begin
      st_mode  = M_IDENT;
      st_emit  = 1'b1;
      st_ident = 1'b1;
      st_km    = (c == "t") ? KM_T : ((c == "f") ? KM_F : KM_NONE);
    end else if (is_digit(c) || c == "." || c == "-") begin
      st_mode = M_NUMBER;
      st_emit = 1'b1;
      st_num  = 1'b1;
    end else begin
      st_mode = M_HALT;
      st_emit = 1'b1;
      st_res  = mk_res(K_EOF, 8'd0, 32'd0);
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    km_nxt   = km_r;
    num_nxt  = num_r;
    res0     = mk_res(K_TEXT, c, 32'd0);
    res1     = st_res;
    n_res    = 2'd0;
    if (is_end) begin
      mode_nxt = M_START;
      km_nxt   = KM_NONE;
      num_nxt  = '0;
      if (mode_r == M_IDENT) begin
        res0  = finish_word(km_r);
        res1  = mk_res(K_EOF, 8'd0, 32'd0);
        n_res = 2'd2;
      end else if (mode_r == M_NUMBER) begin
        res0  = finish_number(num_r);
        res1  = mk_res(K_EOF, 8'd0, 32'd0);
        n_res = 2'd2;
      end else if (mode_r != M_HALT) begin
        res0  = mk_res(K_EOF, 8'd0, 32'd0);
        n_res = 2'd1;
      end
    end else begin
      unique case (mode_r)
        M_SLASH: begin
          if (c == "/") mode_nxt = M_LINE;
          else if (c == "*") mode_nxt = M_BLOCK;
          else begin
            mode_nxt = M_HALT;
            res0     = mk_res(K_EOF, 8'd0, 32'd0);
            n_res    = 2'd1;
          end
        end
        M_LINE: begin
          if (c == 8'h0A) mode_nxt = M_START;
        end
        M_BLOCK: begin
          if (c == "*") mode_nxt = M_STAR;
        end
        M_STAR: begin
          if (c == "/") mode_nxt = M_START;
          else if (c != "*") mode_nxt = M_BLOCK;
        end
        M_STRING: begin
          if (c == "\"") begin
            mode_nxt = M_START;
            res0     = mk_res(K_STRING, 8'd0, 32'd0);
            n_res    = 2'd1;
          end else if (c == "\\") begin
            mode_nxt = M_ESC;
          end else begin
            n_res = 2'd1;
          end
        end
        M_ESC: begin
          mode_nxt = M_STRING;
          n_res    = 2'd1;
          if (c == "n") begin
            res0 = mk_res(K_TEXT, 8'h0A, 32'd0);
          end else if (c != "\"") begin
            // unknown escape: keep the backslash, then the byte
            res0  = mk_res(K_TEXT, "\\", 32'd0);
            res1  = mk_res(K_TEXT, c, 32'd0);
            n_res = 2'd2;
          end
        end
        M_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            km_nxt = keyword_next(km_r, c);
            n_res  = 2'd1;
          end else if (c == "(") begin
            mode_nxt = M_CALL;
            n_res    = 2'd1;
          end else begin
            res0     = finish_word(km_r);
            n_res    = st_emit ? 2'd2 : 2'd1;
            mode_nxt = st_mode;
            if (st_ident) km_nxt = st_km;
            if (st_num) num_nxt = st_numv;
          end
        end
        M_CALL: begin
          n_res = 2'd1;
          if (c == "\"") begin
            mode_nxt = M_CALLQ;
          end else if (c == ")") begin
            mode_nxt = M_START;
            res1     = mk_res(K_EXPR, 8'd0, 32'd0);
            n_res    = 2'd2;
          end
        end
        M_CALLQ: begin
          n_res = 2'd1;
          if (c == "\"") mode_nxt = M_CALL;
        end
        M_NUMBER: begin
          if (is_digit(c) || c == "." || c == "e" || c == "-") begin
            num_nxt = num_step(num_r, c);
            n_res   = 2'd1;
          end else begin
            res0     = finish_number(num_r);
            n_res    = st_emit ? 2'd2 : 2'd1;
            mode_nxt = st_mode;
            if (st_ident) km_nxt = st_km;
            if (st_num) num_nxt = st_numv;
          end
        end
        M_HALT: begin
          mode_nxt = M_HALT;
        end
        M_START: begin
          res0     = st_res;
          n_res    = st_emit ? 2'd1 : 2'd0;
          mode_nxt = st_mode;
          if (st_ident) km_nxt = st_km;
          if (st_num) num_nxt = st_numv;
        end
        default: begin
          mode_nxt = M_START;
        end
      endcase
    end
  end

  assign push           = accept && (n_res != 2'd0);
  assign push_entry.two = (n_res == 2'd2);
  assign push_entry.r0  = res0;
  assign push_entry.r1  = res1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_START;
      km_r   <= KM_NONE;
      num_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      km_r   <= km_nxt;
      num_r  <= num_nxt;
    end
  end

endmodule

// ===== sv/ttt_queue.sv =====
module ttt_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ttt_pkg::q_entry_t push_entry,
  input  logic              pop,
  output ttt_pkg::q_entry_t head,
  output ttt_pkg::q_stat_t  q_stat
);
  import ttt_pkg::*;

  q_entry_t       mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  assign wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
  assign rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
  assign cnt_nxt    = cnt_r + QCW'(push) - QCW'(pop);

  assign head             = mem_r[rd_ptr_r];
  assign q_stat.full      = (cnt_r == QCW'(QDEPTH));
  assign q_stat.not_empty = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop) rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("word pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !q_stat.not_empty))
    else $error("word popped from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> cnt_r == $past(cnt_r) + QCW'($past(push)) - QCW'($past(pop)))
    else $error("queue fill count out of step with push and pop");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != QCW'(QDEPTH)) |-> (QAW'(cnt_r) == QAW'(wr_ptr_r - rd_ptr_r)))
    else $error("queue pointers disagree with fill count");

endmodule

// ===== sv/ttt_back.sv =====
module ttt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ttt_pkg::q_entry_t head,
  input  ttt_pkg::q_stat_t  q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [3:0]        out_token_kind,
  output logic [7:0]        out_text_byte,
  output logic signed [31:0] out_int_value,
  output logic              out_last_of_run
);
  import ttt_pkg::*;

  logic     valid_r;
  tok_res_t res_r;
  logic     last_r;
  logic     idx_r;
  logic     load;
  logic     last_of_entry;
  tok_res_t cur;

  assign load          = q_stat.not_empty && (!valid_r || !out_stall);
  assign last_of_entry = idx_r || !head.two;
  assign pop           = load && last_of_entry;
  assign cur           = idx_r ? head.r1 : head.r0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        // advance to the second word of the entry, or back to the first on pop
        idx_r   <= !last_of_entry;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= cur;
      last_r <= last_of_entry;
    end
  end

  assign out_valid       = valid_r;
  assign out_token_kind  = res_r.kind;
  assign out_text_byte   = res_r.text;
  assign out_int_value   = res_r.value;
  assign out_last_of_run = last_r;

endmodule

// ===== sv/table_text_tokenizer_unit.sv =====
// Tokenizer for table text, one byte per word on the input channel.
// Path: a byte's first result is written into the queue, then loaded into the output
// register that drives the outputs.
// Throughput: one byte per cycle while the queue is not full; output side drains one result
// per cycle while out_stall is low, and a byte that yields two results is absorbed by a 4-entry queue.
// Reset (synchronous, rst_n low): scanner returns to between-tokens, queue and output empty.
module table_text_tokenizer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_input_byte,
  input  logic               in_end_of_input,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_token_kind,
  output logic [7:0]         out_text_byte,
  output logic signed [31:0] out_int_value,
  output logic               out_last_of_run
);
  import ttt_pkg::*;

  q_stat_t  q_stat;
  q_entry_t push_entry;
  q_entry_t head;
  logic     push;
  logic     pop;

  ttt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_input_byte   (in_input_byte),
    .in_end_of_input (in_end_of_input),
    .q_stat          (q_stat),
    .push            (push),
    .push_entry      (push_entry)
  );

  ttt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  ttt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_kind  (out_token_kind),
    .out_text_byte   (out_text_byte),
    .out_int_value   (out_int_value),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import ttt_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
  } word_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  text;
    logic [31:0] value;
    logic        last;
  } tok_t;

  typedef enum logic [3:0] {
    SC_START, SC_SLASH, SC_LINE, SC_BLOCK, SC_STAR, SC_STR,
    SC_ESC, SC_WORD, SC_CALL, SC_CALLQ, SC_NUM, SC_HALT
  } scan_t;

  localparam logic [63:0] MAG_CAP = 64'd1 << (INT_WIDTH - 1);

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_input_byte = 8'd0;
  logic               in_end_of_input = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         out_token_kind;
  logic [7:0]         out_text_byte;
  logic signed [31:0] out_int_value;
  logic               out_last_of_run;

  word_t pend[$];
  tok_t  tokens_due[$];
  tok_t  step_res[$];
  int    items_left = 0;
  int    mismatches = 0;
  int    in_gap = 0;
  int    in_calm = 0;
  int    out_wait = 0;
  int    out_calm = 0;

  string kw_words[8] = '{"true", "false", "tru", "fals", "truex", "falsee", "t", "f"};
  string num_edges[4] = '{"2147483647", "2147483648", "-2147483648", "-2147483649"};

  // scanner state of the predictor
  scan_t       sc_mode = SC_START;
  logic [3:0]  kw_pos = KM_NONE;
  logic [63:0] mag = '0;
  logic        neg_num = 1'b0;
  logic        stopped = 1'b0;
  logic        frac_num = 1'b0;

  table_text_tokenizer_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_input_byte   (in_input_byte),
    .in_end_of_input (in_end_of_input),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_kind  (out_token_kind),
    .out_text_byte   (out_text_byte),
    .out_int_value   (out_int_value),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400us;
    $display("simulation failed");
    $finish;
  end

  function automatic logic is_ws(logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_let(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void put_tok(logic [3:0] kind, logic [7:0] text, logic [31:0] value);
    tok_t t;
    t.kind  = kind;
    t.text  = text;
    t.value = value;
    t.last  = 1'b0;
    step_res.push_back(t);
  endfunction

  function automatic logic [3:0] kw_step(logic [3:0] km, logic [7:0] c);
    logic [7:0] want;
    case (km)
      KM_T:    want = "r";
      KM_TR:   want = "u";
      KM_TRU:  want = "e";
      KM_F:    want = "a";
      KM_FA:   want = "l";
      KM_FAL:  want = "s";
      KM_FALS: want = "e";
      default: want = 8'd0;
    endcase
    return (want != 8'd0 && c == want) ? km + 4'd1 : KM_NONE;
  endfunction

  function automatic void num_char(logic [7:0] c);
    logic [63:0] grown;
    grown = mag * 64'd10 + (64'(c) - 64'("0"));
    if (is_dig(c)) begin
      if (!stopped) mag = (grown > MAG_CAP) ? MAG_CAP : grown;
    end else if (c == "-") begin
      stopped = 1'b1;
    end else begin
      stopped  = 1'b1;
      frac_num = 1'b1;
    end
  endfunction

  function automatic void close_number();
    logic [63:0] v;
    if (frac_num) begin
      put_tok(K_EXPR, 8'd0, 32'd0);
    end else begin
      v = neg_num ? -mag : ((mag >= MAG_CAP) ? MAG_CAP - 64'd1 : mag);
      put_tok(K_INT, 8'd0, v[31:0]);
    end
  endfunction

  function automatic void close_word();
    if (kw_pos == KM_TRUE) put_tok(K_BOOL, 8'd0, 32'd1);
    else if (kw_pos == KM_FALSE) put_tok(K_BOOL, 8'd0, 32'd0);
    else put_tok(K_IDENT, 8'd0, 32'd0);
  endfunction

  function automatic void begin_token(logic [7:0] c);
    sc_mode = SC_START;
    if (is_ws(c)) return;
    case (c)
      "/":  sc_mode = SC_SLASH;
      "{":  put_tok(K_LBRACE, 8'd0, 32'd0);
      "}":  put_tok(K_RBRACE, 8'd0, 32'd0);
      "[":  put_tok(K_LBRACK, 8'd0, 32'd0);
      "]":  put_tok(K_RBRACK, 8'd0, 32'd0);
      "=":  put_tok(K_EQUAL, 8'd0, 32'd0);
      ",":  put_tok(K_COMMA, 8'd0, 32'd0);
      "\"": sc_mode = SC_STR;
      default: begin
        if (is_let(c)) begin
          sc_mode = SC_WORD;
          kw_pos  = (c == "t") ? KM_T : ((c == "f") ? KM_F : KM_NONE);
          put_tok(K_TEXT, c, 32'd0);
        end else if (is_dig(c) || c == "." || c == "-") begin
          sc_mode  = SC_NUM;
          mag      = '0;
          stopped  = 1'b0;
          frac_num = 1'b0;
          neg_num  = (c == "-");
          if (c != "-") num_char(c);
          put_tok(K_TEXT, c, 32'd0);
        end else begin
          put_tok(K_EOF, 8'd0, 32'd0);
          sc_mode = SC_HALT;
        end
      end
    endcase
  endfunction

  // Work out the results of one accepted word and queue them.
  task automatic scan_word(logic [7:0] c, logic eoi);
    tok_t t;
    step_res.delete();
    if (eoi || c == 8'd0) begin
      if (sc_mode == SC_WORD) close_word();
      else if (sc_mode == SC_NUM) close_number();
      if (sc_mode != SC_HALT) put_tok(K_EOF, 8'd0, 32'd0);
      sc_mode  = SC_START;
      kw_pos   = KM_NONE;
      mag      = '0;
      neg_num  = 1'b0;
      stopped  = 1'b0;
      frac_num = 1'b0;
    end else begin
      case (sc_mode)
        SC_SLASH: begin
          if (c == "/") sc_mode = SC_LINE;
          else if (c == "*") sc_mode = SC_BLOCK;
          else begin
            put_tok(K_EOF, 8'd0, 32'd0);
            sc_mode = SC_HALT;
          end
        end
        SC_LINE:  if (c == 8'h0A) sc_mode = SC_START;
        SC_BLOCK: if (c == "*") sc_mode = SC_STAR;
        SC_STAR: begin
          if (c == "/") sc_mode = SC_START;
          else if (c != "*") sc_mode = SC_BLOCK;
        end
        SC_STR: begin
          if (c == "\"") begin
            put_tok(K_STRING, 8'd0, 32'd0);
            sc_mode = SC_START;
          end else if (c == "\\") begin
            sc_mode = SC_ESC;
          end else begin
            put_tok(K_TEXT, c, 32'd0);
          end
        end
        SC_ESC: begin
          if (c == "\"") put_tok(K_TEXT, "\"", 32'd0);
          else if (c == "n") put_tok(K_TEXT, 8'h0A, 32'd0);
          else begin
            put_tok(K_TEXT, "\\", 32'd0);
            put_tok(K_TEXT, c, 32'd0);
          end
          sc_mode = SC_STR;
        end
        SC_WORD: begin
          if (is_let(c) || is_dig(c) || c == "_") begin
            put_tok(K_TEXT, c, 32'd0);
            kw_pos = kw_step(kw_pos, c);
          end else if (c == "(") begin
            put_tok(K_TEXT, c, 32'd0);
            sc_mode = SC_CALL;
          end else begin
            close_word();
            begin_token(c);
          end
        end
        SC_CALL: begin
          put_tok(K_TEXT, c, 32'd0);
          if (c == "\"") sc_mode = SC_CALLQ;
          else if (c == ")") begin
            put_tok(K_EXPR, 8'd0, 32'd0);
            sc_mode = SC_START;
          end
        end
        SC_CALLQ: begin
          put_tok(K_TEXT, c, 32'd0);
          if (c == "\"") sc_mode = SC_CALL;
        end
        SC_NUM: begin
          if (is_dig(c) || c == "." || c == "e" || c == "-") begin
            num_char(c);
            put_tok(K_TEXT, c, 32'd0);
          end else begin
            close_number();
            begin_token(c);
          end
        end
        SC_HALT: ;
        default: begin_token(c);
      endcase
    end
    if (step_res.size() > 0) begin
      t = step_res.pop_back();
      t.last = 1'b1;
      step_res.push_back(t);
    end
    for (int k = 0; k < step_res.size(); k++) tokens_due.push_back(step_res[k]);
  endtask

  // stimulus construction

  function automatic void add_byte(logic [7:0] b, logic e);
    word_t w;
    w.b   = b;
    w.eoi = e;
    pend.push_back(w);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
  endfunction

  function automatic logic [7:0] any_byte_but(logic [7:0] x, logic [7:0] y);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == x || c == y);
    return c;
  endfunction

  function automatic logic [7:0] rand_let();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_dig();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic void add_ident();
    int n;
    int r;
    if ($urandom_range(0, 2) == 0) begin
      add_text(kw_words[$urandom_range(0, 7)]);
    end else begin
      add_byte(rand_let(), 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) begin
        r = $urandom_range(0, 3);
        if (r == 0) add_byte(rand_dig(), 1'b0);
        else if (r == 1) add_byte("_", 1'b0);
        else add_byte(rand_let(), 1'b0);
      end
    end
  endfunction

  function automatic void add_string();
    int n;
    int r;
    add_byte("\"", 1'b0);
    n = $urandom_range(0, 8);
    repeat (n) begin
      r = $urandom_range(0, 5);
      if (r == 0) begin
        add_byte("\\", 1'b0);
        r = $urandom_range(0, 2);
        if (r == 0) add_byte("\"", 1'b0);
        else if (r == 1) add_byte("n", 1'b0);
        else add_byte(8'($urandom_range(1, 255)), 1'b0);
      end else begin
        add_byte(any_byte_but("\"", "\\"), 1'b0);
      end
    end
    add_byte("\"", 1'b0);
  endfunction

  function automatic void add_call();
    int n;
    int m;
    add_ident();
    add_byte("(", 1'b0);
    n = $urandom_range(0, 4);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) begin
        // quoted part may hold a closing paren
        add_byte("\"", 1'b0);
        m = $urandom_range(0, 4);
        repeat (m) add_byte(($urandom_range(0, 1) == 0) ? 8'(")") : any_byte_but("\"", "\""),
                            1'b0);
        add_byte("\"", 1'b0);
      end else begin
        add_byte(any_byte_but(")", "\""), 1'b0);
      end
    end
    add_byte(")", 1'b0);
  endfunction

  function automatic void add_number();
    string lead;
    string body;
    int    n;
    lead = "0123456789.-";
    body = "0123456789.e-";
    case ($urandom_range(0, 5))
      0: add_text(num_edges[$urandom_range(0, 3)]);
      1: add_byte("-", 1'b0);
      2: begin
        add_byte(lead[$urandom_range(0, 11)], 1'b0);
        n = $urandom_range(0, 5);
        repeat (n) add_byte(body[$urandom_range(0, 12)], 1'b0);
      end
      3: begin
        n = $urandom_range(0, 3);
        repeat (n) add_byte(rand_dig(), 1'b0);
        add_byte(($urandom_range(0, 1) == 0) ? 8'(".") : 8'("e"), 1'b0);
        n = $urandom_range(0, 3);
        repeat (n) add_byte(rand_dig(), 1'b0);
      end
      default: begin
        if ($urandom_range(0, 2) == 0) add_byte("-", 1'b0);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
        repeat (n) add_byte(rand_dig(), 1'b0);
      end
    endcase
  endfunction

  // Separate tokens; an open word or number always needs a byte that closes it.
  function automatic void add_sep(logic open_tok);
    string punct;
    int    n;
    punct = "{}[]=,";
    case ($urandom_range(open_tok ? 1 : 0, 4))
      0: ;
      1: begin
        n = $urandom_range(1, 3);
        repeat (n) add_byte(($urandom_range(0, 1) == 0) ? 8'(" ") : 8'(8'h09 + $urandom_range(0, 4)),
                            1'b0);
      end
      2: add_byte(punct[$urandom_range(0, 5)], 1'b0);
      3: begin
        add_text("//");
        n = $urandom_range(0, 5);
        repeat (n) add_byte(any_byte_but(8'h0A, 8'h0A), 1'b0);
        add_byte(8'h0A, 1'b0);
      end
      default: begin
        add_text("/*");
        n = $urandom_range(0, 5);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            add_byte("*", 1'b0);
            add_byte(any_byte_but("/", "*"), 1'b0);
          end else begin
            add_byte(any_byte_but("*", "*"), 1'b0);
          end
        end
        add_text(($urandom_range(0, 2) == 0) ? "**/" : "*/");
      end
    endcase
  endfunction

  function automatic void gen_doc();
    int   ntok;
    int   first;
    int   cut;
    logic open_tok;
    first    = pend.size();
    open_tok = 1'b0;
    ntok     = $urandom_range(1, 12);
    for (int k = 0; k < ntok; k++) begin
      add_sep(open_tok);
      open_tok = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 9: add_string();
        2, 3: begin
          add_ident();
          open_tok = 1'b1;
        end
        4: add_call();
        5, 6, 7: begin
          add_number();
          open_tok = 1'b1;
        end
        default: begin
          add_byte(8'($urandom_range(1, 255)), 1'b0);
          open_tok = 1'b1;
        end
      endcase
    end
    // broken document: drop its tail
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(first, pend.size());
      while (pend.size() > cut) void'(pend.pop_back());
    end
    if ($urandom_range(0, 2) == 0) add_byte(8'd0, 1'b0);
    else add_byte(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_word(in_input_byte, in_end_of_input);
        items_left--;
        in_gap = draw_wait(in_calm);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pend.size() > 0) begin
          w = pend.pop_front();
          in_input_byte   <= w.b;
          in_end_of_input <= w.eoi;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    tok_t t;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tokens_due.size() == 0) begin
          $error("unexpected word: kind %0d text %0d value %0d", out_token_kind,
                 out_text_byte, out_int_value);
          mismatches++;
        end else begin
          t = tokens_due.pop_front();
          check_field("token_kind", t.kind, out_token_kind);
          check_field("text_byte", t.text, out_text_byte);
          check_field("int_value", t.value, out_int_value);
          check_field("last_of_run", t.last, out_last_of_run);
        end
        out_wait = draw_wait(out_calm);
      end else if (out_wait > 0) begin
        out_wait--;
      end
      out_stall <= (out_wait > 0);
    end
  end

  initial begin
    add_text("{[t=true,f=false]=\"\\\"\\n\\q\"}");
    add_byte(8'hFF, 1'b1);
    add_text("x(\")\")-.5e2 -2147483649/**/99999999999 //");
    add_byte(8'hFF, 1'b0);
    add_text("\n-");
    add_byte(8'd0, 1'b0);
    add_text("/*a**/");
    add_byte(8'h0B, 1'b0);
    add_byte(8'h0C, 1'b0);
    add_byte(8'h0D, 1'b0);
    add_text("\ttrue/q~");
    add_byte(8'd0, 1'b1);
    add_text("2147483648~");
    add_byte(8'h41, 1'b1);
    add_text("false");
    add_byte(8'd0, 1'b0);
    while (pend.size() < 400) gen_doc();
    items_left = pend.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (items_left != 0 || tokens_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (tokens_due.size() != 0) begin
      $error("%0d expected words never arrived", tokens_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== table_text_tokenizer_unit.f =====
sv/ttt_pkg.sv
sv/ttt_front.sv
sv/ttt_queue.sv
sv/ttt_back.sv
sv/table_text_tokenizer_unit.sv
sim/tb_top.sv
